### rtl/msseq_pkg.sv
`default_nettype none

package msseq_pkg;

    // Score memory depth; positions are 12 bits wide, so the next index wraps at 4096
    localparam int unsigned SCORE_DEPTH = 4096;
    localparam int unsigned POS_W       = 12;

    // Entry codes and argument markers
    localparam logic [7:0] END_MARK       = 8'hFE;
    localparam logic [7:0] CODE_REST      = 8'hFF;
    localparam logic [7:0] CODE_BEAT      = 8'hFD;
    localparam logic [7:0] CODE_TRANSPOSE = 8'hFC;
    localparam logic [7:0] CODE_MARK      = 8'hFB;
    localparam logic [7:0] CODE_REPEAT    = 8'hFA;

    // Configuration register indexes and reset values
    localparam logic       CFG_DEFAULT_BEAT = 1'b0;
    localparam logic       CFG_GAP          = 1'b1;
    localparam logic [7:0] RESET_BEAT       = 8'd150;
    localparam logic [7:0] RESET_GAP        = 8'd5;

    localparam logic [8:0] PITCH_COUNT = 9'd100;

    // Depth of the decoded-command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [7:0]       entry_code;
        logic [7:0]       entry_arg;
        logic             start_of_score;
    } entry_t;

    typedef struct packed {
        logic [POS_W-1:0] next_position;
        logic             timed;
        logic             tone_on;
        logic [15:0]      reload_value;
        logic [15:0]      sound_ms;
        logic [7:0]       silence_ms;
        logic             finished;
        logic             bad_pitch;
    } result_t;

    // Decoded command word: everything the back end needs to build a result
    typedef struct packed {
        logic [POS_W-1:0] next_position;
        logic             timed;
        logic             tone_on;
        logic             finished;
        logic             bad_pitch;
        logic [6:0]       pitch_idx;
        logic [7:0]       full_beats;
        logic [7:0]       beat_ms;
        logic [7:0]       last_ms;
        logic [7:0]       silence_ms;
    } cmd_t;

    function automatic logic [15:0] pitch_reload(input logic [6:0] idx);
        logic [15:0] r;
        unique case (idx)
            7'd0:  r = 16'h91E9;  7'd1:  r = 16'h9813;  7'd2:  r = 16'h9DE8;
            7'd3:  r = 16'hA374;  7'd4:  r = 16'hA89F;  7'd5:  r = 16'hAD8B;
            7'd6:  r = 16'hB225;  7'd7:  r = 16'hB688;  7'd8:  r = 16'hBAAA;
            7'd9:  r = 16'hBE8C;  7'd10: r = 16'hC23B;  7'd11: r = 16'hC5B1;
            7'd12: r = 16'hC8F4;  7'd13: r = 16'hCC0D;  7'd14: r = 16'hCEF8;
            7'd15: r = 16'hD1B7;  7'd16: r = 16'hD450;  7'd17: r = 16'hD6C3;
            7'd18: r = 16'hD915;  7'd19: r = 16'hDB44;  7'd20: r = 16'hDD53;
            7'd21: r = 16'hDF46;  7'd22: r = 16'hE11C;  7'd23: r = 16'hE2D8;
            7'd24: r = 16'hE47B;  7'd25: r = 16'hE607;  7'd26: r = 16'hE77C;
            7'd27: r = 16'hE8DC;  7'd28: r = 16'hEA28;  7'd29: r = 16'hEB62;
            7'd30: r = 16'hEC8A;  7'd31: r = 16'hEDA2;  7'd32: r = 16'hEEAA;
            7'd33: r = 16'hEFA3;  7'd34: r = 16'hF08E;  7'd35: r = 16'hF16C;
            7'd36: r = 16'hF23D;  7'd37: r = 16'hF303;  7'd38: r = 16'hF3BE;
            7'd39: r = 16'hF46E;  7'd40: r = 16'hF514;  7'd41: r = 16'hF5B1;
            7'd42: r = 16'hF645;  7'd43: r = 16'hF6D1;  7'd44: r = 16'hF755;
            7'd45: r = 16'hF7D1;  7'd46: r = 16'hF847;  7'd47: r = 16'hF8B6;
            7'd48: r = 16'hF91F;  7'd49: r = 16'hF982;  7'd50: r = 16'hF9DF;
            7'd51: r = 16'hFA37;  7'd52: r = 16'hFA8A;  7'd53: r = 16'hFAD9;
            7'd54: r = 16'hFB23;  7'd55: r = 16'hFB68;  7'd56: r = 16'hFBAA;
            7'd57: r = 16'hFBE9;  7'd58: r = 16'hFC23;  7'd59: r = 16'hFC5B;
            7'd60: r = 16'hFC8F;  7'd61: r = 16'hFCC1;  7'd62: r = 16'hFCEF;
            7'd63: r = 16'hFD1B;  7'd64: r = 16'hFD45;  7'd65: r = 16'hFD6C;
            7'd66: r = 16'hFD91;  7'd67: r = 16'hFDB4;  7'd68: r = 16'hFDD5;
            7'd69: r = 16'hFDF4;  7'd70: r = 16'hFE12;  7'd71: r = 16'hFE2D;
            7'd72: r = 16'hFE48;  7'd73: r = 16'hFE60;  7'd74: r = 16'hFE78;
            7'd75: r = 16'hFE8E;  7'd76: r = 16'hFEA3;  7'd77: r = 16'hFEB6;
            7'd78: r = 16'hFEC9;  7'd79: r = 16'hFEDA;  7'd80: r = 16'hFEEB;
            7'd81: r = 16'hFEFA;  7'd82: r = 16'hFF09;  7'd83: r = 16'hFF17;
            7'd84: r = 16'hFF24;  7'd85: r = 16'hFF30;  7'd86: r = 16'hFF3C;
            7'd87: r = 16'hFF47;  7'd88: r = 16'hFF51;  7'd89: r = 16'hFF5B;
            7'd90: r = 16'hFF64;  7'd91: r = 16'hFF6D;  7'd92: r = 16'hFF75;
            7'd93: r = 16'hFF7D;  7'd94: r = 16'hFF84;  7'd95: r = 16'hFF8B;
            7'd96: r = 16'hFF92;  7'd97: r = 16'hFF98;  7'd98: r = 16'hFF9E;
            7'd99: r = 16'hFFA3;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/melody_score_sequencer_core.sv
`default_nettype none

// Melody score sequencer: takes one score entry word per cycle on the entry
// channel and returns one result word per entry, in order, on the result
// channel. The front end decodes each entry against the running beat,
// transpose and repeat state and updates that state in the same cycle, so
// entries flow back to back at one word per clock while the command queue
// has room. A two-word command queue parts the front end from the back end,
// which forms the sound time with one 8x8 multiply, looks up the timer
// reload word and holds the result in an output register. An accepted entry
// is written into the queue and moves on into the output register when that
// register is free or being taken; result valid is its valid flag. A new
// gap applies from the next entry, a new default beat from the next score
// start. Configuration writes (default beat, gap) must be made by the user
// while the block is idle; the block does not enforce this.
module melody_score_sequencer_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port
    input  wire logic                 cfg_en,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_data,
    // Entry channel
    input  wire logic                 entry_valid,
    output logic                      entry_ready,
    input  wire msseq_pkg::entry_t    entry,
    // Result channel
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output msseq_pkg::result_t        result
);
    import msseq_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_head;
    logic queue_full;
    logic queue_has_word;
    logic queue_pop;
    logic entry_take;

    // Accept a word whenever the queue has room; the queue absorbs a stalled back end
    assign entry_ready = !queue_full;
    assign entry_take  = entry_valid && entry_ready;

    msseq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (entry_take),
        .entry     (entry),
        .cmd       (front_cmd)
    );

    msseq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (entry_take),
        .push_word (front_cmd),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_has_word),
        .head      (queue_head)
    );

    // Drain the queue into the output register whenever it is free or being taken
    msseq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_has_word),
        .cmd          (queue_head),
        .cmd_pop      (queue_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

### rtl/msseq_front.sv
`default_nettype none

module msseq_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_en,
    input  wire logic            cfg_index,
    input  wire logic [7:0]      cfg_data,
    input  wire logic            take,
    input  wire msseq_pkg::entry_t entry,
    output msseq_pkg::cmd_t      cmd
);
    import msseq_pkg::*;

    logic [7:0]       default_beat_reg, default_beat_next;
    logic [7:0]       gap_reg, gap_next;
    logic [7:0]       beat_reg, beat_next;
    logic [7:0]       transpose_reg, transpose_next;
    logic [POS_W-1:0] mark_reg, mark_next;
    logic [7:0]       repeats_reg, repeats_next;

    // State as seen by this entry, after an optional score-start reset
    logic [7:0]       beat_cur, transpose_cur, repeats_cur;
    logic [POS_W-1:0] mark_cur;
    logic [8:0]       pitch_sum;

    always_comb
    begin
        default_beat_next = default_beat_reg;
        gap_next          = gap_reg;
        if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_BEAT: default_beat_next = cfg_data;
                CFG_GAP:          gap_next          = cfg_data;
                default:          gap_next          = gap_reg;
            endcase
        end
    end

    always_comb
    begin
        beat_cur      = entry.start_of_score ? default_beat_reg : beat_reg;
        transpose_cur = entry.start_of_score ? 8'd0 : transpose_reg;
        mark_cur      = entry.start_of_score ? '0 : mark_reg;
        repeats_cur   = entry.start_of_score ? 8'd0 : repeats_reg;
        pitch_sum     = {entry.entry_code[7], entry.entry_code}
                      + {transpose_cur[7], transpose_cur};

        beat_next      = beat_cur;
        transpose_next = transpose_cur;
        mark_next      = mark_cur;
        repeats_next   = repeats_cur;

        cmd               = '0;
        cmd.next_position = entry.position + POS_W'(1);
        cmd.pitch_idx     = pitch_sum[6:0];

        priority if (entry.entry_arg == END_MARK)
        begin
            cmd.finished      = 1'b1;
            cmd.next_position = entry.position;
        end
        else if (entry.entry_code == CODE_BEAT)
        begin
            beat_next = entry.entry_arg;
        end
        else if (entry.entry_code == CODE_TRANSPOSE)
        begin
            transpose_next = entry.entry_arg;
        end
        else if (entry.entry_code == CODE_MARK)
        begin
            mark_next    = entry.position;
            repeats_next = entry.entry_arg;
        end
        else if (entry.entry_code == CODE_REPEAT)
        begin
            if (repeats_cur != 8'd0)
            begin
                cmd.next_position = mark_cur + POS_W'(1);
            end
            repeats_next = repeats_cur - 8'd1;
        end
        else
        begin
            cmd.timed      = 1'b1;
            cmd.silence_ms = gap_reg;
            cmd.full_beats = entry.entry_arg - 8'd1;
            cmd.beat_ms    = beat_cur;
            cmd.last_ms    = (beat_cur > gap_reg) ? beat_cur - gap_reg : 8'd0;
            if (entry.entry_code != CODE_REST)
            begin
                // Index must land in 0..99 as a signed sum
                if (!pitch_sum[8] && (pitch_sum < PITCH_COUNT))
                begin
                    cmd.tone_on = 1'b1;
                end
                else
                begin
                    cmd.bad_pitch = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_beat_reg <= RESET_BEAT;
            gap_reg          <= RESET_GAP;
            beat_reg         <= RESET_BEAT;
            transpose_reg    <= '0;
            mark_reg         <= '0;
            repeats_reg      <= '0;
        end
        else
        begin
            default_beat_reg <= default_beat_next;
            gap_reg          <= gap_next;
            if (take)
            begin
                beat_reg      <= beat_next;
                transpose_reg <= transpose_next;
                mark_reg      <= mark_next;
                repeats_reg   <= repeats_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/msseq_queue.sv
`default_nettype none

module msseq_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire msseq_pkg::cmd_t push_word,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output msseq_pkg::cmd_t      head
);
    import msseq_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

### rtl/msseq_back.sv
`default_nettype none

module msseq_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire msseq_pkg::cmd_t cmd,
    output logic                 cmd_pop,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output msseq_pkg::result_t   result
);
    import msseq_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic [15:0] beats_product;
    logic [16:0] sound_sum;

    assign cmd_pop      = cmd_valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        beats_product = cmd.full_beats * cmd.beat_ms;
        sound_sum     = {1'b0, beats_product} + {9'd0, cmd.last_ms};

        out_next               = '0;
        out_next.next_position = cmd.next_position;
        out_next.timed         = cmd.timed;
        out_next.tone_on       = cmd.tone_on;
        out_next.reload_value  = cmd.tone_on ? pitch_reload(cmd.pitch_idx) : 16'd0;
        out_next.sound_ms      = sound_sum[15:0];
        out_next.silence_ms    = cmd.silence_ms;
        out_next.finished      = cmd.finished;
        out_next.bad_pitch     = cmd.bad_pitch;

        out_valid_next = cmd_pop ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### tb/msseq_result_checker.sv
`timescale 1ns / 1ps

module msseq_result_checker
    import msseq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_en,
    input  wire logic    cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic    entry_valid,
    input  wire logic    entry_ready,
    input  wire entry_t  entry,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result,
    output int unsigned  fail_count,
    output int unsigned  pending_results
);

    // Timer reload words, lowest pitch first
    localparam logic [0:99][15:0] TONE_RELOAD = {
        16'h91E9, 16'h9813, 16'h9DE8, 16'hA374, 16'hA89F,
        16'hAD8B, 16'hB225, 16'hB688, 16'hBAAA, 16'hBE8C,
        16'hC23B, 16'hC5B1, 16'hC8F4, 16'hCC0D, 16'hCEF8,
        16'hD1B7, 16'hD450, 16'hD6C3, 16'hD915, 16'hDB44,
        16'hDD53, 16'hDF46, 16'hE11C, 16'hE2D8, 16'hE47B,
        16'hE607, 16'hE77C, 16'hE8DC, 16'hEA28, 16'hEB62,
        16'hEC8A, 16'hEDA2, 16'hEEAA, 16'hEFA3, 16'hF08E,
        16'hF16C, 16'hF23D, 16'hF303, 16'hF3BE, 16'hF46E,
        16'hF514, 16'hF5B1, 16'hF645, 16'hF6D1, 16'hF755,
        16'hF7D1, 16'hF847, 16'hF8B6, 16'hF91F, 16'hF982,
        16'hF9DF, 16'hFA37, 16'hFA8A, 16'hFAD9, 16'hFB23,
        16'hFB68, 16'hFBAA, 16'hFBE9, 16'hFC23, 16'hFC5B,
        16'hFC8F, 16'hFCC1, 16'hFCEF, 16'hFD1B, 16'hFD45,
        16'hFD6C, 16'hFD91, 16'hFDB4, 16'hFDD5, 16'hFDF4,
        16'hFE12, 16'hFE2D, 16'hFE48, 16'hFE60, 16'hFE78,
        16'hFE8E, 16'hFEA3, 16'hFEB6, 16'hFEC9, 16'hFEDA,
        16'hFEEB, 16'hFEFA, 16'hFF09, 16'hFF17, 16'hFF24,
        16'hFF30, 16'hFF3C, 16'hFF47, 16'hFF51, 16'hFF5B,
        16'hFF64, 16'hFF6D, 16'hFF75, 16'hFF7D, 16'hFF84,
        16'hFF8B, 16'hFF92, 16'hFF98, 16'hFF9E, 16'hFFA3
    };

    logic [7:0]       default_beat;
    logic [7:0]       gap_len;
    logic [7:0]       beat_len;
    logic [7:0]       transpose;
    logic [POS_W-1:0] repeat_mark;
    logic [7:0]       repeats_left;

    result_t     expected_results[$];
    result_t     oldest;
    int unsigned errs;

    function automatic result_t decode_entry(input entry_t e);
        result_t    r;
        logic [7:0] full_beats;
        logic [7:0] last_beat;
        int         pitch;
        r = '0;
        r.next_position = e.position + 1'b1;
        if (e.start_of_score)
        begin
            beat_len     = default_beat;
            transpose    = '0;
            repeat_mark  = '0;
            repeats_left = '0;
        end
        if (e.entry_arg == END_MARK)
        begin
            r.finished      = 1'b1;
            r.next_position = e.position;
        end
        else if (e.entry_code == CODE_BEAT)
            beat_len = e.entry_arg;
        else if (e.entry_code == CODE_TRANSPOSE)
            transpose = e.entry_arg;
        else if (e.entry_code == CODE_MARK)
        begin
            repeat_mark  = e.position;
            repeats_left = e.entry_arg;
        end
        else if (e.entry_code == CODE_REPEAT)
        begin
            if (repeats_left != 0)
                r.next_position = repeat_mark + 1'b1;
            repeats_left = repeats_left - 8'd1;
        end
        else
        begin
            // all beats but the last run full; the last one gives up the gap
            full_beats   = e.entry_arg - 8'd1;
            last_beat    = (beat_len > gap_len) ? beat_len - gap_len : 8'd0;
            r.timed      = 1'b1;
            r.silence_ms = gap_len;
            r.sound_ms   = full_beats * beat_len + last_beat;
            if (e.entry_code != CODE_REST)
            begin
                pitch = int'($signed(e.entry_code)) + int'($signed(transpose));
                if (pitch >= 0 && pitch < 100)
                begin
                    r.tone_on      = 1'b1;
                    r.reload_value = TONE_RELOAD[pitch];
                end
                else
                    r.bad_pitch = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_beat = RESET_BEAT;
            gap_len      = RESET_GAP;
            beat_len     = RESET_BEAT;
            transpose    = '0;
            repeat_mark  = '0;
            repeats_left = '0;
            errs         = 0;
            expected_results.delete();
            fail_count      <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_en)
            begin
                if (cfg_index == CFG_DEFAULT_BEAT)
                    default_beat = cfg_data;
                else
                    gap_len = cfg_data;
            end
            if (entry_valid && entry_ready)
                expected_results.push_back(decode_entry(entry));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no entry outstanding");
                    errs++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("next_position", oldest.next_position, result.next_position);
                    check_field("timed", oldest.timed, result.timed);
                    check_field("tone_on", oldest.tone_on, result.tone_on);
                    check_field("reload_value", oldest.reload_value, result.reload_value);
                    check_field("sound_ms", oldest.sound_ms, result.sound_ms);
                    check_field("silence_ms", oldest.silence_ms, result.silence_ms);
                    check_field("finished", oldest.finished, result.finished);
                    check_field("bad_pitch", oldest.bad_pitch, result.bad_pitch);
                end
            end
            pending_results <= expected_results.size();
            fail_count      <= errs;
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import msseq_pkg::*;

    // Clock and reset; every block input starts at a known value
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_en       = 1'b0;
    logic       cfg_index    = 1'b0;
    logic [7:0] cfg_data     = '0;
    logic       entry_valid  = 1'b0;
    logic       entry_ready;
    entry_t     entry_word   = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result_word;

    int unsigned fail_count;
    int unsigned pending_results;
    int unsigned words_sent  = 0;

    // Stimulus side flags: zero-gap stretches, and the long result hold-offs
    bit burst_mode = 1'b0;
    bit squeeze    = 1'b0;

    melody_score_sequencer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry_valid  (entry_valid),
        .entry_ready  (entry_ready),
        .entry        (entry_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_word)
    );

    msseq_result_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_en          (cfg_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .entry_valid     (entry_valid),
        .entry_ready     (entry_ready),
        .entry           (entry_word),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result_word),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("melody_score_sequencer_core test failed");
        $finish;
    end

    // Mostly short idle gaps on the entry side, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Beat counts: mostly short notes, sometimes the 256-beat zero or anything
    function automatic logic [7:0] pick_beats();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'($urandom_range(1, 8));
        if (r < 88)
            return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one entry word and hold it until the block takes it. Valid is
    // only dropped when an idle gap comes first, so back-to-back words keep
    // valid high with a single assignment per edge.
    task automatic send_word(input logic [POS_W-1:0] pos, input logic [7:0] code,
                             input logic [7:0] arg, input logic start);
        int     gap;
        entry_t w;
        w.position       = pos;
        w.entry_code     = code;
        w.entry_arg      = arg;
        w.start_of_score = start;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0)
        begin
            entry_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        entry_valid <= 1'b1;
        entry_word  <= w;
        @(posedge clk);
        while (!entry_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Drain the block: drop valid, wait for every outstanding result word,
    // then let the block settle before touching registers.
    task automatic drain();
        entry_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] beat_val, input logic [7:0] gap_val);
        cfg_en    <= 1'b1;
        cfg_index <= CFG_DEFAULT_BEAT;
        cfg_data  <= beat_val;
        @(posedge clk);
        cfg_index <= CFG_GAP;
        cfg_data  <= gap_val;
        @(posedge clk);
        cfg_en    <= 1'b0;
    endtask

    // One well-formed score: a start entry, a body of notes, rests and
    // control entries with random content, then the end marker. A small
    // share of words is pure noise, which may also restart the score.
    task automatic play_score();
        logic [POS_W-1:0] pos;
        logic [7:0]       code;
        logic [7:0]       arg;
        logic             start;
        int               len;
        int               r;
        int               shift;
        pos = POS_W'($urandom_range(0, SCORE_DEPTH - 1));
        if ($urandom_range(0, 7) == 0)
            pos = '1 - POS_W'($urandom_range(0, 5));
        len = $urandom_range(4, 24);
        burst_mode = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
        begin
            start = (k == 0);
            r     = $urandom_range(0, 99);
            if (r < 50)
            begin
                // pitch codes around the table range, sometimes anywhere
                if ($urandom_range(0, 9) == 0)
                    code = 8'($urandom_range(0, 8'hF9));
                else
                    code = 8'($urandom_range(0, 99));
                arg = pick_beats();
            end
            else if (r < 60)
            begin
                code = CODE_REST;
                arg  = pick_beats();
            end
            else if (r < 68)
            begin
                code = CODE_BEAT;
                arg  = 8'($urandom_range(0, 255));
            end
            else if (r < 75)
            begin
                code = CODE_TRANSPOSE;
                if ($urandom_range(0, 4) == 0)
                    arg = 8'($urandom_range(0, 255));
                else
                begin
                    shift = int'($urandom_range(0, 48)) - 24;
                    arg   = shift[7:0];
                end
            end
            else if (r < 82)
            begin
                code = CODE_MARK;
                arg  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 4));
            end
            else if (r < 92)
            begin
                code = CODE_REPEAT;
                arg  = 8'($urandom_range(0, 255));
            end
            else
            begin
                code  = 8'($urandom_range(0, 255));
                arg   = 8'($urandom_range(0, 255));
                start = 1'($urandom_range(0, 1));
            end
            send_word(pos, code, arg, start);
            pos = pos + 1'b1;
        end
        send_word(pos, 8'($urandom_range(0, 255)), END_MARK, 1'b0);
    endtask

    // Result side: runs of steady ready, random ready, short and medium
    // stalls. When the squeeze flag is raised, hold ready low for a long
    // stretch so the block backs up and stalls its entry channel.
    initial
    begin
        int   mode;
        int   run;
        logic level;
        forever
        begin
            if (squeeze)
            begin
                squeeze = 1'b0;
                result_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 9);
                run  = $urandom_range(1, 40);
                if (mode == 8)
                    run = $urandom_range(1, 4);
                else if (mode == 9)
                    run = $urandom_range(10, 60);
                for (int k = 0; k < run && !squeeze; k++)
                begin
                    if (mode < 4)
                        level = 1'b1;
                    else if (mode < 8)
                        level = ($urandom_range(0, 3) != 0);
                    else
                        level = 1'b0;
                    result_ready <= level;
                    @(posedge clk);
                end
            end
        end
    end

    // Entry side: reset, directed entries at reset settings, then one random
    // phase per register setting, draining the block between phases.
    initial
    begin
        logic [7:0] beat_val;
        logic [7:0] gap_val;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pitch table ends, 256 beats, above and below the table
        send_word(12'd0,    8'h00,          8'd1,     1'b1);
        send_word(12'd1,    8'h63,          8'd0,     1'b0);
        send_word(12'd2,    8'h64,          8'd1,     1'b0);
        send_word(12'd3,    8'h80,          8'hFF,    1'b0);
        send_word(12'd4,    CODE_REST,      8'd2,     1'b0);
        // end-marker code used with a normal argument is pitch minus two, a bad pitch
        send_word(12'd5,    END_MARK,       8'd3,     1'b0);
        // beat shorter than the gap: the last beat saturates at zero
        send_word(12'd6,    CODE_BEAT,      8'd3,     1'b0);
        send_word(12'd7,    8'h10,          8'd1,     1'b0);
        send_word(12'd8,    CODE_BEAT,      8'hFF,    1'b0);
        send_word(12'd9,    8'h7F,          8'hFF,    1'b0);
        // negative and positive transposes around the table edges
        send_word(12'd10,   CODE_TRANSPOSE, 8'h9C,    1'b0);
        send_word(12'd11,   8'h7F,          8'd1,     1'b0);
        send_word(12'd12,   8'h63,          8'd1,     1'b0);
        send_word(12'd13,   CODE_TRANSPOSE, 8'h64,    1'b0);
        send_word(12'd14,   8'hF9,          8'd1,     1'b0);
        send_word(12'd15,   8'h80,          8'd1,     1'b0);
        // repeat twice, fall through on zero, then the wrapped count jumps again
        send_word(12'd16,   CODE_MARK,      8'd2,     1'b0);
        send_word(12'd18,   CODE_REPEAT,    8'd0,     1'b0);
        send_word(12'd18,   CODE_REPEAT,    8'h11,    1'b0);
        send_word(12'd18,   CODE_REPEAT,    8'd0,     1'b0);
        send_word(12'd19,   CODE_REPEAT,    8'd0,     1'b0);
        // end marker with a note code and with a control code
        send_word(12'd20,   8'h33,          END_MARK, 1'b0);
        send_word(12'd21,   CODE_BEAT,      END_MARK, 1'b0);
        // last position wraps; repeat end with no mark set uses mark zero
        send_word(12'hFFF,  8'h05,          8'd1,     1'b0);
        send_word(12'hFFF,  CODE_REPEAT,    8'd7,     1'b1);
        send_word(12'd30,   CODE_REPEAT,    8'd0,     1'b0);
        send_word(12'hFFF,  CODE_MARK,      8'd1,     1'b0);
        send_word(12'd100,  CODE_REPEAT,    8'd0,     1'b0);
        send_word(12'd200,  8'h10,          END_MARK, 1'b1);

        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            case (ph)
                0: begin beat_val = 8'd0;   gap_val = 8'd0;   end
                1: begin beat_val = 8'd255; gap_val = 8'd255; end
                2: begin beat_val = 8'd255; gap_val = 8'd0;   end
                3: begin beat_val = 8'd0;   gap_val = 8'd255; end
                4: begin beat_val = 8'd3;   gap_val = 8'd9;   end
                5:
                begin
                    beat_val = 8'($urandom_range(0, 255));
                    gap_val  = 8'($urandom_range(0, 255));
                end
                default: begin beat_val = RESET_BEAT; gap_val = RESET_GAP; end
            endcase
            load_settings(beat_val, gap_val);
            while (words_sent < 30 + (ph + 1) * 265)
            begin
                play_score();
                // back up the whole pipeline early in this phase while entries keep coming
                if (ph == 2 && words_sent < 30 + 2 * 265 + 40)
                    squeeze = 1'b1;
            end
        end

        // let every result word arrive, then let the block settle
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("melody_score_sequencer_core test passed");
        else
            $display("melody_score_sequencer_core test failed");
        $finish;
    end

endmodule
